// ----- hdl/wra_pkg.sv -----
// ----------------------------------------------------------------------------
// wra_pkg: shared constants of the windowed running average
// Field widths, the register reset value and parameter defaults.
// ----------------------------------------------------------------------------
package wra_pkg;

   localparam int SAMPLE_WIDTH       = 32;
   localparam int WINDOW_FIELD_WIDTH = 6;
   localparam int MAX_WINDOW_DEFAULT = 32;

   localparam logic [WINDOW_FIELD_WIDTH-1:0] WINDOW_RESET = WINDOW_FIELD_WIDTH'(20);

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;

endpackage

// ----- hdl/windowed_running_average.sv -----
// ----------------------------------------------------------------------------
// windowed_running_average: moving-average filter over a sample window
// Keeps the most recent samples in a ring, a running sum and a fill count,
// and returns the sum divided by the fill count, truncated toward zero.
// ----------------------------------------------------------------------------
// Usage:
// Samples enter on the req_ stream channel and one average per sample leaves
// on the rsp_ channel, in order. The window size is written through csr_,
// by the user only while the block is idle; the block does not enforce this.
// A write clears the held samples, as reset does. A value of zero acts as
// one, a value above MAX_WINDOW as MAX_WINDOW. Each sample runs through a
// bit-serial adder that updates the running sum and a restoring divider that
// yields one quotient bit per cycle. A new sample is taken only once the
// last one's average is done and registered. The result sits in an output
// register, so the next sample is accepted while the receiver stalls; if the
// receiver still holds off when that sample is done, the block waits with it.
// Reset clears the state, loads the window size 20 and needs no clearing
// pass: ring slots not yet written this fill read as zero by the fill count.
// ----------------------------------------------------------------------------
module windowed_running_average
   import wra_pkg::*;
#(
   parameter int MAX_WINDOW = MAX_WINDOW_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   // req_tdata: sample [31:0]
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic signed [SAMPLE_WIDTH-1:0] req_tdata,
   // rsp_tdata: average [31:0]
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_tdata,
   input  logic                          csr_wr_en,
   input  logic [WINDOW_FIELD_WIDTH-1:0] csr_wr_data
);

   localparam int CNT_WIDTH  = $clog2(MAX_WINDOW + 1);
   localparam int SLOT_WIDTH = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int CMP_WIDTH  = (CNT_WIDTH > WINDOW_FIELD_WIDTH) ? CNT_WIDTH
                                                                 : WINDOW_FIELD_WIDTH;
   localparam int SUM_WIDTH  = SAMPLE_WIDTH + $clog2(MAX_WINDOW);
   localparam int CTR_WIDTH  = $clog2(SUM_WIDTH);

   localparam logic [CTR_WIDTH-1:0] LAST_BIT = CTR_WIDTH'(SUM_WIDTH - 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_LOAD = 3'd1;
   localparam logic [2:0] ST_ADD  = 3'd2;
   localparam logic [2:0] ST_ABS  = 3'd3;
   localparam logic [2:0] ST_DIV  = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   logic [2:0]                    state_ff, state_in;
   logic [WINDOW_FIELD_WIDTH-1:0] window_ff;
   logic [CNT_WIDTH-1:0]          fill_ff;
   logic [SLOT_WIDTH-1:0]         slot_ff;
   logic [CTR_WIDTH-1:0]          ctr_ff;
   logic [SUM_WIDTH-1:0]          sum_ff;
   logic [SAMPLE_WIDTH-1:0]       new_ff;
   logic [SAMPLE_WIDTH-1:0]       old_ff;
   logic [SAMPLE_WIDTH-1:0]       ring_rd_ff;
   logic                          carry_a_ff;
   logic                          carry_b_ff;
   logic [SUM_WIDTH-1:0]          quot_ff;
   logic [CNT_WIDTH-1:0]          rem_ff;
   logic                          neg_ff;
   logic                          rsp_valid_ff;
   logic [SAMPLE_WIDTH-1:0]       rsp_data_ff;

   logic [SAMPLE_WIDTH-1:0] ring_mem [MAX_WINDOW];

   logic                 accept;
   logic                 out_free;
   logic [CMP_WIDTH-1:0] window_ext;
   logic [CMP_WIDTH-1:0] eff_ext;
   logic [CNT_WIDTH-1:0] eff_window;
   logic [CNT_WIDTH-1:0] slot_next;
   logic                 add_a, add_b;
   logic                 carry_a_in, carry_b_in;
   logic [CNT_WIDTH:0]   trial;
   logic                 trial_fits;
   logic [SAMPLE_WIDTH-1:0] quot_low;

   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Clamp the window register into the range the ring supports.
   always_comb begin
      window_ext = CMP_WIDTH'(window_ff);
      if (window_ext == '0) begin
         eff_ext = CMP_WIDTH'(1);
      end else if (window_ext > CMP_WIDTH'(MAX_WINDOW)) begin
         eff_ext = CMP_WIDTH'(MAX_WINDOW);
      end else begin
         eff_ext = window_ext;
      end
      eff_window = eff_ext[CNT_WIDTH-1:0];
      slot_next  = CNT_WIDTH'(slot_ff) + CNT_WIDTH'(1);
   end

   // Serial sum - old + new: first add the new bit, then add the inverted old
   // bit with a carry that starts at one.
   always_comb begin
      add_a      = sum_ff[0] ^ new_ff[0] ^ carry_a_ff;
      carry_a_in = (sum_ff[0] & new_ff[0]) | (sum_ff[0] & carry_a_ff)
                 | (new_ff[0] & carry_a_ff);
      add_b      = add_a ^ ~old_ff[0] ^ carry_b_ff;
      carry_b_in = (add_a & ~old_ff[0]) | (add_a & carry_b_ff)
                 | (~old_ff[0] & carry_b_ff);
   end

   always_comb begin
      trial      = {rem_ff, quot_ff[SUM_WIDTH-1]};
      trial_fits = (trial >= {1'b0, fill_ff});
      quot_low   = quot_ff[SAMPLE_WIDTH-1:0];
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_LOAD;
         end
         ST_LOAD: state_in = ST_ADD;
         ST_ADD: begin
            if (ctr_ff == LAST_BIT) state_in = ST_ABS;
         end
         ST_ABS: state_in = ST_DIV;
         ST_DIV: begin
            if (ctr_ff == LAST_BIT) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         window_ff    <= WINDOW_RESET;
         fill_ff      <= '0;
         slot_ff      <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;

         // A finished average replaces the one that leaves in this cycle.
         if (state_ff == ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         // A window write restarts the filter from an empty ring.
         if (csr_wr_en) begin
            window_ff <= csr_wr_data;
            fill_ff   <= '0;
            slot_ff   <= '0;
            sum_ff    <= '0;
         end else begin
            case (state_ff)
               ST_LOAD: begin
                  if (slot_next >= eff_window) begin
                     slot_ff <= '0;
                  end else begin
                     slot_ff <= slot_next[SLOT_WIDTH-1:0];
                  end
                  if (fill_ff < eff_window) fill_ff <= fill_ff + CNT_WIDTH'(1);
               end
               ST_ADD: sum_ff <= {add_b, sum_ff[SUM_WIDTH-1:1]};
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            new_ff <= req_tdata;
         end
         ST_LOAD: begin
            // Slots not yet written since the last clear are read as zero.
            old_ff     <= (fill_ff < eff_window) ? '0 : ring_rd_ff;
            ctr_ff     <= '0;
            carry_a_ff <= 1'b0;
            carry_b_ff <= 1'b1;
         end
         ST_ADD: begin
            new_ff     <= {new_ff[SAMPLE_WIDTH-1], new_ff[SAMPLE_WIDTH-1:1]};
            old_ff     <= {old_ff[SAMPLE_WIDTH-1], old_ff[SAMPLE_WIDTH-1:1]};
            carry_a_ff <= carry_a_in;
            carry_b_ff <= carry_b_in;
            ctr_ff     <= ctr_ff + CTR_WIDTH'(1);
         end
         ST_ABS: begin
            neg_ff  <= sum_ff[SUM_WIDTH-1];
            quot_ff <= sum_ff[SUM_WIDTH-1] ? (~sum_ff + SUM_WIDTH'(1)) : sum_ff;
            rem_ff  <= '0;
            ctr_ff  <= '0;
         end
         ST_DIV: begin
            if (trial_fits) begin
               rem_ff <= CNT_WIDTH'(trial - {1'b0, fill_ff});
            end else begin
               rem_ff <= trial[CNT_WIDTH-1:0];
            end
            quot_ff <= {quot_ff[SUM_WIDTH-2:0], trial_fits};
            ctr_ff  <= ctr_ff + CTR_WIDTH'(1);
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_data_ff <= neg_ff ? (~quot_low + SAMPLE_WIDTH'(1)) : quot_low;
            end
         end
         default: ;
      endcase
   end

   // Sample ring: the old entry is read as the new one is written.
   always_ff @(posedge clock) begin
      if (accept) begin
         ring_mem[slot_ff] <= req_tdata;
         ring_rd_ff        <= ring_mem[slot_ff];
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= eff_window)
      else $error("fill count exceeds the window");

   assert property (@(posedge clock) disable iff (reset)
      (fill_ff < eff_window) |-> (CNT_WIDTH'(slot_ff) == fill_ff))
      else $error("write slot and fill count disagree while filling");

   assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_LOAD))
      else $error("accepted sample did not start the update");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADD && ctr_ff == LAST_BIT) |=> (state_ff == ST_ABS))
      else $error("serial sum update ran the wrong number of cycles");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && out_free) |=> rsp_valid_ff)
      else $error("finished average was not presented");
`endif

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the windowed running average
// Streams signed samples into the filter and checks every returned average
// against its typed value or an in-bench model of the ring, the wide sum and
// the fill count. A short table covers the extremes and the window-size corner
// cases; random phases then rewrite the window size and send random samples
// while both stream sides stall at random, with one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
   import wra_pkg::*;

   localparam int RANDOM_SAMPLES   = 1000;
   localparam int IDLE_PERCENT     = 15;
   localparam int QUIET_FIRST      = 500;
   localparam int QUIET_LAST       = 650;
   localparam int HOLD_OFF_AT      = 300;
   localparam int HOLD_OFF_CYCLES  = 500;
   localparam int SETTLE_CYCLES    = 8;
   localparam int DRAIN_CYCLES     = 100;
   localparam int STALL_LIMIT      = 4000;
   localparam int SLOT_BITS        = $clog2(MAX_WINDOW_DEFAULT);

   typedef enum bit {ROW_SAMPLE, ROW_WINDOW} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [31:0] value;
      bit         typed;
      sample_type typed_average;
   } step_row_type;

   localparam int DIRECTED_ROWS = 24;

   // Typed averages are the ones that are obvious: the first sample after a
   // clear, a window of one or two samples, or one holding only one value.
   step_row_type directed_steps [DIRECTED_ROWS] = '{
      '{ROW_SAMPLE, 32'sd100,         1'b1, 32'sd100},
      '{ROW_SAMPLE, 32'sh7FFF_FFFF,   1'b0, 32'sd0},
      '{ROW_SAMPLE, 32'sh8000_0000,   1'b0, 32'sd0},
      '{ROW_SAMPLE, -32'sd7,          1'b0, 32'sd0},
      '{ROW_WINDOW, 32'd1,            1'b0, 32'sd0},
      '{ROW_SAMPLE, 32'sh7FFF_FFFF,   1'b1, 32'sh7FFF_FFFF},
      '{ROW_SAMPLE, 32'sh8000_0000,   1'b1, 32'sh8000_0000},
      '{ROW_SAMPLE, -32'sd5,          1'b1, -32'sd5},
      '{ROW_WINDOW, 32'd0,            1'b0, 32'sd0},
      '{ROW_SAMPLE, 32'sd12345,       1'b1, 32'sd12345},
      '{ROW_SAMPLE, -32'sd1,          1'b1, -32'sd1},
      '{ROW_WINDOW, 32'd63,           1'b0, 32'sd0},
      '{ROW_SAMPLE, 32'sh7FFF_FFFF,   1'b1, 32'sh7FFF_FFFF},
      '{ROW_SAMPLE, 32'sh7FFF_FFFF,   1'b1, 32'sh7FFF_FFFF},
      '{ROW_SAMPLE, 32'sh7FFF_FFFF,   1'b1, 32'sh7FFF_FFFF},
      '{ROW_SAMPLE, 32'sh8000_0000,   1'b0, 32'sd0},
      '{ROW_SAMPLE, 32'sh8000_0000,   1'b0, 32'sd0},
      '{ROW_WINDOW, 32'd2,            1'b0, 32'sd0},
      '{ROW_SAMPLE, -32'sd3,          1'b1, -32'sd3},
      '{ROW_SAMPLE, 32'sd0,           1'b1, -32'sd1},
      '{ROW_SAMPLE, 32'sd4,           1'b0, 32'sd0},
      '{ROW_WINDOW, 32'd2,            1'b0, 32'sd0},
      '{ROW_SAMPLE, 32'sd9,           1'b1, 32'sd9},
      '{ROW_SAMPLE, -32'sd2,          1'b0, 32'sd0}
   };

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic signed [SAMPLE_WIDTH-1:0] req_tdata = '0;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic signed [SAMPLE_WIDTH-1:0] rsp_tdata;
   logic                          csr_wr_en = 1'b0;
   logic [WINDOW_FIELD_WIDTH-1:0] csr_wr_data = '0;

   windowed_running_average u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Model of the filter state.
   logic [WINDOW_FIELD_WIDTH-1:0] window_reg;
   sample_type                    held_samples [MAX_WINDOW_DEFAULT];
   longint                        held_sum;
   int unsigned                   next_slot;
   int unsigned                   held_count;

   sample_type pending_averages [$];
   int         samples_sent  = 0;
   int         averages_seen = 0;
   int         fail_count    = 0;
   bit         hold_off_done = 1'b0;

   function automatic void clear_window();
      foreach (held_samples[i]) held_samples[i] = '0;
      held_sum   = 0;
      next_slot  = 0;
      held_count = 0;
   endfunction

   function automatic sample_type advance_average(sample_type s);
      int unsigned span;
      span = 32'(window_reg);
      if (span < 1) span = 1;
      if (span > MAX_WINDOW_DEFAULT) span = MAX_WINDOW_DEFAULT;
      held_sum = held_sum - longint'(held_samples[next_slot[SLOT_BITS-1:0]]) + longint'(s);
      held_samples[next_slot[SLOT_BITS-1:0]] = s;
      next_slot = (next_slot + 1 >= span) ? 0 : next_slot + 1;
      if (held_count < span) held_count++;
      return sample_type'(held_sum / longint'(held_count));
   endfunction

   function automatic sample_type random_sample();
      case ($urandom_range(0, 9))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2, 3, 4: return sample_type'(int'($urandom_range(0, 200)) - 100);
         5: return sample_type'(32'h7FFF_FF00 | $urandom_range(0, 255));
         6: return sample_type'(32'h8000_0000 | $urandom_range(0, 255));
         default: return sample_type'($urandom);
      endcase
   endfunction

   function automatic logic [WINDOW_FIELD_WIDTH-1:0] random_window();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return WINDOW_FIELD_WIDTH'(1);
         2: return WINDOW_FIELD_WIDTH'(MAX_WINDOW_DEFAULT);
         3: return '1;
         4: return WINDOW_RESET;
         5: return WINDOW_FIELD_WIDTH'($urandom_range(33, 62));
         default: return WINDOW_FIELD_WIDTH'($urandom_range(1, 31));
      endcase
   endfunction

   function automatic bit in_quiet_span(int count);
      return count >= QUIET_FIRST && count < QUIET_LAST;
   endfunction

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_sample(sample_type s, bit typed, sample_type typed_average);
      sample_type predicted;
      while (!in_quiet_span(samples_sent) && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = s;
      do @(posedge clock); while (!req_tready);
      predicted = advance_average(s);
      pending_averages.push_back(typed ? typed_average : predicted);
      samples_sent++;
      @(negedge clock);
   endtask

   // The window size is only rewritten once the filter has drained.
   task automatic load_window(logic [WINDOW_FIELD_WIDTH-1:0] size);
      req_tvalid = 1'b0;
      while (pending_averages.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = size;
      @(negedge clock);
      csr_wr_en = 1'b0;
      window_reg = size;
      clear_window();
   endtask

   // Stimulus.
   initial begin
      int span;
      window_reg = WINDOW_RESET;
      clear_window();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_steps[i]) begin
         if (directed_steps[i].kind == ROW_WINDOW)
            load_window(directed_steps[i].value[WINDOW_FIELD_WIDTH-1:0]);
         else
            send_sample(sample_type'(directed_steps[i].value), directed_steps[i].typed,
                        directed_steps[i].typed_average);
      end

      while (samples_sent < DIRECTED_ROWS + RANDOM_SAMPLES) begin
         load_window(random_window());
         span = $urandom_range(8, 120);
         repeat (span) send_sample(random_sample(), 1'b0, '0);
      end

      req_tvalid = 1'b0;
      while (pending_averages.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0)
         $display("[windowed_running_average] OK");
      else
         $display("[windowed_running_average] ERROR");
      $finish;
   end

   // Receiver: random stalls, a quiet stretch, and one long hold-off while the
   // sender keeps offering so that the output register fills and req stalls.
   initial begin
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (!hold_off_done && averages_seen >= HOLD_OFF_AT && req_tvalid) begin
            rsp_tready = 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_off_done = 1'b1;
         end
         rsp_tready = in_quiet_span(averages_seen) || $urandom_range(0, 99) >= IDLE_PERCENT;
      end
   end

   // Result checker.
   always @(posedge clock) begin
      sample_type wanted;
      if (!reset && rsp_tvalid && rsp_tready) begin
         averages_seen++;
         if (pending_averages.size() == 0) begin
            $error("average transfer with nothing expected: actual %0d", rsp_tdata);
            fail_count++;
         end else begin
            wanted = pending_averages.pop_front();
            if (rsp_tdata !== wanted) begin
               $error("average mismatch: expected %0d, actual %0d", wanted, rsp_tdata);
               fail_count++;
            end
         end
      end
   end

   // Watchdog on cycles without any transfer.
   int stalled_cycles = 0;
   always @(posedge clock) begin
      if (reset || csr_wr_en || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stalled_cycles <= 0;
      else if (stalled_cycles >= STALL_LIMIT) begin
         $display("[windowed_running_average] ERROR");
         $finish;
      end else
         stalled_cycles <= stalled_cycles + 1;
   end

endmodule
